@@ rtl/core/q2e_pkg.sv @@
`default_nettype none
package q2e_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;

   // Widths: quaternion, matrix terms, CORDIC vector, angle, square-root word
   localparam int QW   = 16;
   localparam int MW   = 35;
   localparam int SW   = 30;
   localparam int CW   = 38;
   localparam int AW   = 28;
   localparam int RW   = 58;
   localparam int OW   = 16;
   localparam int SQ_STEPS = 29;

   localparam int DEG_ONE = 65536;
   localparam logic signed [AW-1:0] DEG_90  = AW'(90 * DEG_ONE);
   localparam logic signed [AW-1:0] DEG_180 = AW'(180 * DEG_ONE);
   localparam logic signed [AW-1:0] DEG_360 = AW'(360 * DEG_ONE);
   localparam logic [OW-1:0]        OUT_MAX = OW'(46080);

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [AW-1:0] atan_q16(input int i);
      logic signed [AW-1:0] v;
      case (i)
         0:  v = AW'(2949120);
         1:  v = AW'(1740967);
         2:  v = AW'(919879);
         3:  v = AW'(466945);
         4:  v = AW'(234379);
         5:  v = AW'(117304);
         6:  v = AW'(58666);
         7:  v = AW'(29335);
         8:  v = AW'(14668);
         9:  v = AW'(7334);
         10: v = AW'(3667);
         11: v = AW'(1833);
         12: v = AW'(917);
         13: v = AW'(458);
         14: v = AW'(229);
         15: v = AW'(115);
         16: v = AW'(57);
         17: v = AW'(29);
         18: v = AW'(14);
         19: v = AW'(7);
         20: v = AW'(4);
         21: v = AW'(2);
         22: v = AW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/q2e_cordic.sv @@
`default_nettype none
module q2e_cordic
   import q2e_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [CW-1:0] x_in,
   input  wire logic signed [CW-1:0] y_in,
   output logic signed [AW-1:0]      z_out
);

   localparam int NS = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

   logic signed [CW-1:0] x_ff [0:NS];
   logic signed [CW-1:0] y_ff [0:NS];
   logic signed [AW-1:0] z_ff [0:NS];
   logic                 zero_ff [0:NS];

   // Pre-rotate left half-plane vectors by a quarter turn
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_ff[0] <= y_in;
               y_ff[0] <= -x_in;
               z_ff[0] <= DEG_90;
            end else begin
               x_ff[0] <= -y_in;
               y_ff[0] <= x_in;
               z_ff[0] <= -DEG_90;
            end
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   // One micro-rotation per stage
   for (genvar i = 0; i < NS; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q16(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q16(i);
            end
         end
      end
   end

   assign z_out = zero_ff[NS] ? '0 : z_ff[NS];

endmodule
`default_nettype wire

@@ rtl/core/quaternion_to_euler_360_top.sv @@
// Each beat passes the product, matrix, root-setup, square-root, CORDIC and output registers in turn.
// Throughput: one quaternion per cycle while the result beat is not stalled; every stage advances together.
// The 29-stage square-root pipeline and the CORDIC stages set the latency.
// Reset (synchronous, active high) clears all valid bits; data needs no reset.
`default_nettype none
module quaternion_to_euler_360_top
   import q2e_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata   // yaw_deg, pitch_deg, roll_deg
);

   localparam int NS  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int LAT = 3 + SQ_STEPS + 1 + NS + 1;

   logic en;
   logic vld_ff [0:LAT-1];

   // Advance the whole pipe unless the output beat is stuck
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Stage 1: quaternion products
   logic signed [QW-1:0] qw, qx, qy, qz;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xz_ff, wy_ff;
   logic signed [31:0] xy_ff, wz_ff, yz_ff, wx_ff;

   assign qw = req_tdata[15:0];
   assign qx = req_tdata[31:16];
   assign qy = req_tdata[47:32];
   assign qz = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= 32'(qw) * 32'(qw);
         xx_ff <= 32'(qx) * 32'(qx);
         yy_ff <= 32'(qy) * 32'(qy);
         zz_ff <= 32'(qz) * 32'(qz);
         xz_ff <= 32'(qx) * 32'(qz);
         wy_ff <= 32'(qw) * 32'(qy);
         xy_ff <= 32'(qx) * 32'(qy);
         wz_ff <= 32'(qw) * 32'(qz);
         yz_ff <= 32'(qy) * 32'(qz);
         wx_ff <= 32'(qw) * 32'(qx);
      end
   end

   // Stage 2: matrix terms, clamp the asin argument
   logic signed [MW-1:0] gx_in, gz_in, m11_in, m12_in, m31_in, m21_full;
   logic signed [MW-1:0] gz_ff, m11_ff, m12_ff, m31_ff;
   logic signed [SW-1:0] m21_in, m21_ff;
   logic                 gxn_ff;

   always_comb begin
      gx_in  = (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
      gz_in  = MW'(ww_ff) - MW'(xx_ff) - MW'(yy_ff) + MW'(zz_ff);
      m11_in = (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
      m12_in = MW'(ww_ff) + MW'(xx_ff) - MW'(yy_ff) - MW'(zz_ff);
      m31_in = (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
      m21_full = -gx_in;
      if (m21_full > (MW'(1) <<< 28))       m21_in = SW'(1) <<< 28;
      else if (m21_full < -(MW'(1) <<< 28)) m21_in = -(SW'(1) <<< 28);
      else                                  m21_in = SW'(m21_full);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gxn_ff <= gx_in[MW-1];
         gz_ff  <= gz_in;
         m11_ff <= m11_in;
         m12_ff <= m12_in;
         m31_ff <= m31_in;
         m21_ff <= m21_in;
      end
   end

   // Stage 3 and square-root pipe: one root bit per stage
   logic [RW-1:0]        sq_n_ff [0:SQ_STEPS];
   logic [RW-1:0]        sq_r_ff [0:SQ_STEPS];
   logic signed [MW-1:0] p11_ff [0:SQ_STEPS];
   logic signed [MW-1:0] p12_ff [0:SQ_STEPS];
   logic signed [MW-1:0] p31_ff [0:SQ_STEPS];
   logic signed [MW-1:0] p32_ff [0:SQ_STEPS];
   logic signed [SW-1:0] p21_ff [0:SQ_STEPS];
   logic                 pgx_ff [0:SQ_STEPS];
   logic signed [2*SW-1:0] m21_sq;

   assign m21_sq = (2*SW)'(m21_ff) * (2*SW)'(m21_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_n_ff[0] <= (RW'(1) << 56) - RW'(unsigned'(m21_sq));
         sq_r_ff[0] <= '0;
         p11_ff[0]  <= m11_ff;
         p12_ff[0]  <= m12_ff;
         p31_ff[0]  <= m31_ff;
         p32_ff[0]  <= gz_ff;
         p21_ff[0]  <= m21_ff;
         pgx_ff[0]  <= gxn_ff;
      end
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - j));
      logic [RW-1:0] trial;
      assign trial = sq_r_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (sq_n_ff[j] >= trial) begin
               sq_n_ff[j+1] <= sq_n_ff[j] - trial;
               sq_r_ff[j+1] <= (sq_r_ff[j] >> 1) + BIT;
            end else begin
               sq_n_ff[j+1] <= sq_n_ff[j];
               sq_r_ff[j+1] <= sq_r_ff[j] >> 1;
            end
            p11_ff[j+1] <= p11_ff[j];
            p12_ff[j+1] <= p12_ff[j];
            p31_ff[j+1] <= p31_ff[j];
            p32_ff[j+1] <= p32_ff[j];
            p21_ff[j+1] <= p21_ff[j];
            pgx_ff[j+1] <= pgx_ff[j];
         end
      end
   end

   // Three CORDIC pipes side by side
   logic signed [AW-1:0] zy, zp, zr;
   logic signed [CW-1:0] cos_x;

   assign cos_x = signed'(CW'(sq_r_ff[SQ_STEPS]));

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock (clock), .en (en),
      .x_in  (CW'(p12_ff[SQ_STEPS])), .y_in (CW'(p11_ff[SQ_STEPS])),
      .z_out (zy)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock), .en (en),
      .x_in  (cos_x), .y_in (CW'(p21_ff[SQ_STEPS])),
      .z_out (zp)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock), .en (en),
      .x_in  (CW'(p32_ff[SQ_STEPS])), .y_in (CW'(p31_ff[SQ_STEPS])),
      .z_out (zr)
   );

   // Carry the gravity signs alongside the CORDIC stages
   logic gxn_d_ff [0:NS];
   logic gzn_d_ff [0:NS];

   always_ff @(posedge clock) begin
      if (en) begin
         gxn_d_ff[0] <= pgx_ff[SQ_STEPS];
         gzn_d_ff[0] <= p32_ff[SQ_STEPS][MW-1];
         for (int k = 1; k <= NS; k++) begin
            gxn_d_ff[k] <= gxn_d_ff[k-1];
            gzn_d_ff[k] <= gzn_d_ff[k-1];
         end
      end
   end

   // Round half up to 7 fraction bits and clamp
   function automatic logic [OW-1:0] to_out(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] r;
      logic [OW-1:0]        o;
      r = (a + AW'(256)) >>> 9;
      if (a < 0)                        o = '0;
      else if (r > signed'(AW'(OUT_MAX))) o = OUT_MAX;
      else                              o = OW'(r);
      return o;
   endfunction

   // Output stage: unfold, wrap, mirror
   logic signed [AW-1:0] yaw_a, pitch_a, roll_a;
   logic [47:0]          out_ff;

   always_comb begin
      yaw_a = -zy;
      if (yaw_a < 0) yaw_a = yaw_a + DEG_360;
      yaw_a = DEG_360 - yaw_a;
      pitch_a = -zp;
      if (gzn_d_ff[NS])      pitch_a = DEG_180 - pitch_a;
      else if (gxn_d_ff[NS]) pitch_a = DEG_360 + pitch_a;
      roll_a = -zr;
      if (roll_a < 0) roll_a = roll_a + DEG_360;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= {to_out(roll_a), to_out(pitch_a), to_out(yaw_a)};
      end
   end

   assign rsp_tdata = out_ff;

endmodule
`default_nettype wire

@@ rtl/core/q2e_checker.sv @@
`default_nettype none
module q2e_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [63:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // Hold a stalled result beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Pipe advances whenever the output slot frees
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output slot");

   // Angles stay within a full turn
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= 16'd46080 && rsp_tdata[31:16] <= 16'd46080
                     && rsp_tdata[47:32] <= 16'd46080)
      else $error("angle out of range");

   // No result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind quaternion_to_euler_360_top q2e_checker u_q2e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ verif/quaternion_to_euler_360_top_tb.sv @@
`default_nettype none
module quaternion_to_euler_360_top_tb
   import q2e_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  ANGLE_STAGES   = (CORDIC_STEPS_DEF < ATAN_LEN) ? CORDIC_STEPS_DEF : ATAN_LEN;
   localparam int  PIPE_LATENCY   = 34 + ANGLE_STAGES;
   localparam int  STALL_LIMIT    = 5000;
   localparam int  RANDOM_ITEMS   = 1030;
   localparam int  HOLD_START     = 1000;
   localparam int  HOLD_CYCLES    = 400;
   localparam int  STEADY_START   = 200;
   localparam int  STEADY_END     = 700;
   localparam longint DEG_Q16     = 65536;

   localparam longint ATAN_DEG_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic [OW-1:0] roll_deg;
      logic [OW-1:0] pitch_deg;
      logic [OW-1:0] yaw_deg;
   } euler_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // quat_w, quat_x, quat_y, quat_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // yaw_deg, pitch_deg, roll_deg

   logic [63:0] quat_queue [$];
   euler_t      angle_queue [$];
   int          cyc;
   int          errors;
   int          quiet_cycles;

   quaternion_to_euler_360_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Toggle the clock every half period
   always #2 clock = ~clock;

   // Vectoring CORDIC atan2, degrees at Q.16
   function automatic longint vector_angle(input longint y_in, input longint x_in);
      longint x, y, z, t, dx, dy;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 90 * DEG_Q16;
         end else begin
            x = -y; y = t; z = -90 * DEG_Q16;
         end
      end
      for (int i = 0; i < ANGLE_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + ATAN_DEG_Q16[i];
         end else begin
            x = x - dx; y = y + dy; z = z - ATAN_DEG_Q16[i];
         end
      end
      return z;
   endfunction

   // Floor square root
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Round Q.16 degrees to Q.7 and clamp
   function automatic logic [OW-1:0] to_deg_q7(input longint a);
      longint r;
      if (a < 0) return '0;
      r = (a + 256) >>> 9;
      if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
      return OW'(r);
   endfunction

   function automatic euler_t euler_angles(input logic [63:0] q);
      longint w, x, y, z, ww, xx, yy, zz, gx, gz, m11, m12, m21, m31, m32;
      longint cosv, yaw, pitch, roll, one, full;
      euler_t e;
      one  = longint'(1) << 28;
      full = 360 * DEG_Q16;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      ww = w * w; xx = x * x; yy = y * y; zz = z * z;
      gx  = 2 * (x * z - w * y);
      gz  = ww - xx - yy + zz;
      m11 = 2 * (x * y + w * z);
      m12 = ww + xx - yy - zz;
      m21 = -gx;
      m31 = 2 * (y * z + w * x);
      m32 = gz;
      if (m21 > one) m21 = one;
      if (m21 < -one) m21 = -one;
      cosv  = longint'(root_floor(longint'(unsigned'((longint'(1) << 56) - m21 * m21))));
      yaw   = -vector_angle(m11, m12);
      pitch = -vector_angle(m21, cosv);
      roll  = -vector_angle(m31, m32);
      // Unfold pitch over the full turn from the gravity signs
      if (gz < 0) pitch = 180 * DEG_Q16 - pitch;
      else if (gx < 0) pitch = full + pitch;
      if (yaw < 0) yaw = yaw + full;
      if (roll < 0) roll = roll + full;
      yaw = full - yaw;
      e.yaw_deg   = to_deg_q7(yaw);
      e.pitch_deg = to_deg_q7(pitch);
      e.roll_deg  = to_deg_q7(roll);
      return e;
   endfunction

   function automatic logic [63:0] pack_quat(input int w, input int x, input int y, input int z);
      return {16'(z), 16'(y), 16'(x), 16'(w)};
   endfunction

   // Random quaternion: mostly near unit length, some raw and edge values
   function automatic logic [63:0] random_quat();
      int   c [4];
      real  n;
      int   pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         do begin
            n = 0.0;
            for (int i = 0; i < 4; i++) begin
               c[i] = $urandom_range(32768) - 16384;
               n = n + real'(c[i]) * real'(c[i]);
            end
         end while (n < 1.0e6);
         n = $sqrt(n);
         for (int i = 0; i < 4; i++) c[i] = $rtoi(real'(c[i]) * 16384.0 / n);
         // Occasionally jitter the length a little off one
         if ($urandom_range(3) == 0) c[$urandom_range(3)] += $urandom_range(64) - 32;
         return pack_quat(c[0], c[1], c[2], c[3]);
      end else if (pick < 85) begin
         return {$urandom, $urandom};
      end
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(4))
            0: c[i] = 0;
            1: c[i] = 16384;
            2: c[i] = -16384;
            3: c[i] = 11585 * (($urandom_range(1) == 0) ? 1 : -1);
            default: c[i] = $urandom_range(8) - 4;
         endcase
      end
      return pack_quat(c[0], c[1], c[2], c[3]);
   endfunction

   // Drive input beats from the pending queue, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            angle_queue.push_back(euler_angles(req_tdata));
            void'(quat_queue.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (quat_queue.size() > 0 &&
                !((cyc < STEADY_START || cyc > STEADY_END) && $urandom_range(99) < 25)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= quat_queue[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check result beats and drive backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         cyc <= 0;
      end else begin
         cyc <= cyc + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (angle_queue.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               errors++;
            end else begin
               euler_t want, got;
               want = angle_queue.pop_front();
               got  = rsp_tdata;
               if (got.yaw_deg !== want.yaw_deg) begin
                  $error("yaw_deg expected %0d actual %0d", want.yaw_deg, got.yaw_deg);
                  errors++;
               end
               if (got.pitch_deg !== want.pitch_deg) begin
                  $error("pitch_deg expected %0d actual %0d", want.pitch_deg, got.pitch_deg);
                  errors++;
               end
               if (got.roll_deg !== want.roll_deg) begin
                  $error("roll_deg expected %0d actual %0d", want.roll_deg, got.roll_deg);
                  errors++;
               end
            end
         end
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
            rsp_tready <= 1'b0;
         else if (cyc >= STEADY_START && cyc <= STEADY_END)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= 25);
      end
   end

   // Stop the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("quaternion_to_euler_360_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      errors       = 0;
      quiet_cycles = 0;
      cyc          = 0;

      // Directed: zero, identities, axis turns, gimbal lock, field extremes
      quat_queue.push_back(pack_quat(0, 0, 0, 0));
      quat_queue.push_back(pack_quat(16384, 0, 0, 0));
      quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
      quat_queue.push_back(pack_quat(0, 16384, 0, 0));
      quat_queue.push_back(pack_quat(0, 0, 16384, 0));
      quat_queue.push_back(pack_quat(0, 0, 0, 16384));
      quat_queue.push_back(pack_quat(0, -16384, 0, 0));
      quat_queue.push_back(pack_quat(0, 0, -16384, 0));
      quat_queue.push_back(pack_quat(0, 0, 0, -16384));
      quat_queue.push_back(pack_quat(11585, 11585, 0, 0));
      quat_queue.push_back(pack_quat(11585, -11585, 0, 0));
      quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
      quat_queue.push_back(pack_quat(11585, 0, -11585, 0));
      quat_queue.push_back(pack_quat(11585, 0, 0, 11585));
      quat_queue.push_back(pack_quat(11585, 0, 0, -11585));
      quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
      quat_queue.push_back(pack_quat(8192, -8192, 8192, -8192));
      quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
      quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
      quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
      quat_queue.push_back(pack_quat(16384, 16384, 16384, 16384));
      quat_queue.push_back(pack_quat(16383, 1, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // First random batch, then let the pipe drain completely
      for (int i = 0; i < RANDOM_ITEMS / 2; i++) quat_queue.push_back(random_quat());
      @(negedge clock);
      while (quat_queue.size() != 0 || angle_queue.size() != 0) @(negedge clock);

      for (int i = 0; i < RANDOM_ITEMS - RANDOM_ITEMS / 2; i++)
         quat_queue.push_back(random_quat());
      @(negedge clock);
      while (quat_queue.size() != 0 || angle_queue.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 10) @(negedge clock);

      if (errors == 0 && angle_queue.size() == 0) begin
         $display("quaternion_to_euler_360_top_tb: clean");
      end else begin
         $display("quaternion_to_euler_360_top_tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
